// ----- rtl/core/invs_pkg.sv -----
// shared types and constants of the invertible stack
package invs_pkg;

	// fixed field widths of the stream payload
	localparam int FUNC_W    = 2;
	localparam int VALUE_W   = 32;
	localparam int STATUS_W  = 2;
	localparam int COUNT_W   = 5;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 80;

	// parameter defaults
	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;

	// operation codes
	typedef enum logic [FUNC_W-1:0] {
		FN_PUSH   = 2'd0,
		FN_POP    = 2'd1,
		FN_INVERT = 2'd2,
		FN_QUERY  = 2'd3
	} func_t;

	// status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 2'd0,
		ST_POP_EMPTY  = 2'd1,
		ST_PUSH_FULL  = 2'd2
	} status_t;

	// one result beat, lowest field last
	typedef struct packed {
		logic                 is_flipped;
		logic                 is_empty;
		logic [COUNT_W-1:0]   count;
		logic [VALUE_W-1:0]   bottom_value;
		logic [VALUE_W-1:0]   top_value;
		status_t              status;
	} result_t;

endpackage

// ----- rtl/core/invertible_stack.sv -----
// invertible stack top level: stream handshake, result register and checks
//
//  channel  dir  fields (low bit first)                                       width
//  s_*      in   func[1:0], value[33:2], zero pad                              40
//  m_*      out  status[1:0], top_value[33:2], bottom_value[65:34],           80
//                count[70:66], is_empty[71], is_flipped[72], zero pad
//
// one beat per clock unless the output stalls: each operation finishes in the cycle it is
// accepted and its result sits in the output register from the next cycle on
// the ring is read through two registered ports that prefetch the word next to each end
// s_tready is low only while a result is held and m_tready is low
// arst_n clears indices, count and flip flag; ring contents are not cleared
module invertible_stack
	import invs_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // func, value
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata    // status, top_value, bottom_value, count,
	                                        // is_empty, is_flipped
);

	logic    step;
	func_t   func;
	result_t core_res;
	result_t res_q;
	logic    m_valid_q;

	assign s_tready = !m_valid_q || m_tready;
	assign step     = s_tvalid && s_tready;
	assign func     = func_t'(s_tdata[FUNC_W-1:0]);

	invs_core #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.func   (func),
		.value  (s_tdata[FUNC_W +: VALUE_W]),
		.result (core_res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (step) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= core_res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = M_TDATA_W'(res_q);

	// every accepted beat leaves a result behind
	a_beat_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> m_valid_q)
		else $error("accepted beat produced no result");

	// a pop refused for emptiness reports an empty stack
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && (res_q.status == ST_POP_EMPTY)) |-> res_q.is_empty)
		else $error("pop on empty reported a non-empty stack");

	// a push refused for fullness reports a non-empty stack
	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && (res_q.status == ST_PUSH_FULL)) |-> !res_q.is_empty)
		else $error("push on full reported an empty stack");

	// end values read as zero on an empty stack
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && res_q.is_empty) |->
			((res_q.top_value == '0) && (res_q.bottom_value == '0)))
		else $error("empty stack shows nonzero end values");

endmodule

// ----- rtl/core/invs_ring.sv -----
// ring storage with one write port and two registered read ports with write bypass
module invs_ring
	import invs_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int WIDTH = DATA_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic [WIDTH-1:0]         rd_data_a,
	output logic [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_a_q;
	logic [WIDTH-1:0] rd_b_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read ports, a same-cycle write to the address wins
	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr == rd_addr_a)) begin
			rd_a_q <= wr_data;
		end else begin
			rd_a_q <= mem[rd_addr_a];
		end
		if (wr_en && (wr_addr == rd_addr_b)) begin
			rd_b_q <= wr_data;
		end else begin
			rd_b_q <= mem[rd_addr_b];
		end
	end

	assign rd_data_a = rd_a_q;
	assign rd_data_b = rd_b_q;

endmodule

// ----- rtl/core/invs_core.sv -----
// stack state: end indices, count, flip flag, cached end values and the ring
module invs_core
	import invs_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  func_t              func,
	input  logic [VALUE_W-1:0] value,
	output result_t            result
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	// bits above the value field are always zero, so they are not stored
	localparam int KW = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;

	logic [AW-1:0] low_q, high_q, n_low, n_high;
	logic [CW-1:0] cnt_q, n_cnt;
	logic          flip_q, n_flip;
	logic [KW-1:0] lo_val_q, hi_val_q, n_lo_val, n_hi_val;
	logic [KW-1:0] nb_lo, nb_hi;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [KW-1:0] data;
	logic          is_empty_now, is_full_now;
	status_t       status;
	logic [KW-1:0] top_k, bot_k;

	function automatic logic [AW-1:0] idx_up(input logic [AW-1:0] i);
		if (i == AW'(DEPTH - 1)) begin
			return '0;
		end
		return i + AW'(1);
	endfunction

	function automatic logic [AW-1:0] idx_down(input logic [AW-1:0] i);
		if (i == '0) begin
			return AW'(DEPTH - 1);
		end
		return i - AW'(1);
	endfunction

	assign data         = value[KW-1:0];
	assign is_empty_now = (cnt_q == '0);
	assign is_full_now  = (cnt_q == CW'(DEPTH));

	// next state for one operation
	always_comb begin
		n_low    = low_q;
		n_high   = high_q;
		n_cnt    = cnt_q;
		n_flip   = flip_q;
		n_lo_val = lo_val_q;
		n_hi_val = hi_val_q;
		wr_en    = 1'b0;
		wr_addr  = low_q;
		status   = ST_OK;
		case (func)
			FN_PUSH: begin
				if (is_full_now) begin
					status = ST_PUSH_FULL;
				end else begin
					wr_en = 1'b1;
					n_cnt = cnt_q + CW'(1);
					if (is_empty_now) begin
						n_high   = low_q;
						wr_addr  = low_q;
						n_lo_val = data;
						n_hi_val = data;
					end else if (flip_q) begin
						n_high   = idx_up(high_q);
						wr_addr  = idx_up(high_q);
						n_hi_val = data;
					end else begin
						n_low    = idx_down(low_q);
						wr_addr  = idx_down(low_q);
						n_lo_val = data;
					end
				end
			end
			FN_POP: begin
				if (is_empty_now) begin
					status = ST_POP_EMPTY;
				end else begin
					n_cnt = cnt_q - CW'(1);
					if (flip_q) begin
						n_high   = idx_down(high_q);
						n_hi_val = nb_hi;
					end else begin
						n_low    = idx_up(low_q);
						n_lo_val = nb_lo;
					end
				end
			end
			FN_INVERT: begin
				n_flip = ~flip_q;
			end
			default: begin
			end
		endcase
		if (!step) begin
			n_low    = low_q;
			n_high   = high_q;
			n_cnt    = cnt_q;
			n_flip   = flip_q;
			n_lo_val = lo_val_q;
			n_hi_val = hi_val_q;
			wr_en    = 1'b0;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= '0;
			high_q <= '0;
			cnt_q  <= '0;
			flip_q <= 1'b0;
		end else begin
			low_q  <= n_low;
			high_q <= n_high;
			cnt_q  <= n_cnt;
			flip_q <= n_flip;
		end
	end

	// cached values at the two ends
	always_ff @(posedge clk) begin
		lo_val_q <= n_lo_val;
		hi_val_q <= n_hi_val;
	end

	// ring, prefetching the word next to each end for the following pop
	invs_ring #(
		.DEPTH (DEPTH),
		.WIDTH (KW)
	) u_ring (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (data),
		.rd_addr_a (idx_up(n_low)),
		.rd_addr_b (idx_down(n_high)),
		.rd_data_a (nb_lo),
		.rd_data_b (nb_hi)
	);

	// result as it stands after the step
	assign top_k = n_flip ? n_hi_val : n_lo_val;
	assign bot_k = n_flip ? n_lo_val : n_hi_val;

	always_comb begin
		result.status       = status;
		result.count        = COUNT_W'(n_cnt);
		result.is_empty     = (n_cnt == '0);
		result.is_flipped   = n_flip;
		result.top_value    = (n_cnt == '0) ? '0 : VALUE_W'(top_k);
		result.bottom_value = (n_cnt == '0) ? '0 : VALUE_W'(bot_k);
	end

endmodule
